// ----- hw/rtl/mtfo_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mtfo_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned MULT_W = 31;

    localparam logic [WORD_W-1:0] INIT_MULT  = 32'd1812433253;
    localparam logic [WORD_W-1:0] TWIST_MAT  = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] TEMPER_B   = 32'd2636928640;
    localparam logic [WORD_W-1:0] TEMPER_C   = 32'd4022730752;
    localparam logic [WORD_W-1:0] UPPER_BIT  = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOW_MASK   = 32'h7fff_ffff;

    // Last state word produced by the seeding recurrence, and the words we keep.
    localparam int unsigned LAST_WORD = 398;
    localparam int unsigned STEP_W    = $clog2(LAST_WORD + 1);
    localparam logic [STEP_W-1:0] KEEP_W1   = STEP_W'(1);
    localparam logic [STEP_W-1:0] KEEP_W2   = STEP_W'(2);
    localparam logic [STEP_W-1:0] KEEP_W397 = STEP_W'(397);

    // One multiplier stage per recurrence step plus one output stage.
    localparam int unsigned PIPE_LATENCY = LAST_WORD + 1;

    typedef struct packed {
        logic [WORD_W-1:0] seed;
        logic [WORD_W-1:0] w1;
        logic [WORD_W-1:0] w2;
        logic [WORD_W-1:0] w397;
        logic [WORD_W-1:0] w;
    } mtfo_word_t;

    function automatic logic [WORD_W-1:0] mtfo_twist(
        input logic [WORD_W-1:0] hi_src,
        input logic [WORD_W-1:0] lo_src,
        input logic [WORD_W-1:0] far_src
    );
        logic [WORD_W-1:0] joined;
        logic [WORD_W-1:0] res;
        joined = (hi_src & UPPER_BIT) | (lo_src & LOW_MASK);
        res    = far_src ^ (joined >> 1);
        if (joined[0])
        begin
            res = res ^ TWIST_MAT;
        end
        return res;
    endfunction

    function automatic logic [WORD_W-1:0] mtfo_temper(input logic [WORD_W-1:0] v_in);
        logic [WORD_W-1:0] v;
        v = v_in;
        v = v ^ (v >> 11);
        v = v ^ ((v << 7) & TEMPER_B);
        v = v ^ ((v << 15) & TEMPER_C);
        v = v ^ (v >> 18);
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mt19937_first_two_odd_multipliers_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Seed-to-multiplier unit. A request is a 32-bit seed presented with start; busy is
// always low, so a new seed may be issued on every clock cycle. Each seed produces
// exactly one result, in issue order, after passing through the pipeline: one register
// stage per step of the 398-step seeding recurrence (one 32x32 multiply-add each),
// followed by one stage that twists and tempers the first two raw outputs. The result
// (seed_echo, x_multiplier, z_multiplier) is shown for a single cycle with done high.
// The receiver has no way to stall the unit, so it must capture every result in the
// cycle in which done is high. Both multipliers are always odd. Reset clears only
// the valid bits of the pipeline; requests in flight at reset are dropped.
module mt19937_first_two_odd_multipliers_unit
    import mtfo_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [WORD_W-1:0] seed,
    output logic                   done,
    output logic [WORD_W-1:0]      seed_echo,
    output logic [MULT_W-1:0]      x_multiplier,
    output logic [MULT_W-1:0]      z_multiplier
);

    // Stage 0 is the request itself; stage k holds state word k in its w field.
    logic       stage_valid [0:LAST_WORD];
    mtfo_word_t stage_data  [0:LAST_WORD];

    // The pipeline never stalls, so it is always ready for a new seed.
    assign busy = 1'b0;

    always_comb
    begin
        stage_valid[0]      = start;
        stage_data[0].seed  = seed;
        stage_data[0].w1    = '0;
        stage_data[0].w2    = '0;
        stage_data[0].w397  = '0;
        stage_data[0].w     = seed;
    end

    // Each recurrence step is its own multiplier stage; the stages capture words 1, 2
    // and 397 as they pass so that the final stage has everything it needs.
    for (genvar i = 1; i <= LAST_WORD; i++)
    begin : g_step
        mtfo_init_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[i-1]),
            .in_data   (stage_data[i-1]),
            .step_index(STEP_W'(i)),
            .out_valid (stage_valid[i]),
            .out_data  (stage_data[i])
        );
    end

    mtfo_output_stage u_output (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (stage_valid[LAST_WORD]),
        .in_data     (stage_data[LAST_WORD]),
        .done        (done),
        .seed_echo   (seed_echo),
        .x_multiplier(x_multiplier),
        .z_multiplier(z_multiplier)
    );

    // Every request yields a result after the fixed pipeline latency.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##PIPE_LATENCY done)
        else $error("request did not produce a result after the pipeline latency");

    // No result appears without a matching request.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##PIPE_LATENCY !done)
        else $error("result appeared without a request");

    // The echoed seed belongs to the request that entered the pipeline.
    a_seed_echo: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##PIPE_LATENCY (seed_echo == $past(seed, PIPE_LATENCY)))
        else $error("echoed seed does not match its request");

    // Both multipliers are forced odd.
    a_odd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (x_multiplier[0] && z_multiplier[0]))
        else $error("multiplier is not odd");

endmodule

`default_nettype wire

// ----- hw/rtl/mtfo_init_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One step of the seeding recurrence: w = INIT_MULT * (w ^ (w >> 30)) + step.
module mtfo_init_stage
    import mtfo_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire mtfo_word_t        in_data,
    input  wire logic [STEP_W-1:0] step_index,
    output logic                   out_valid,
    output mtfo_word_t             out_data
);

    logic              valid_reg;
    mtfo_word_t        data_reg;
    mtfo_word_t        data_next;
    logic [WORD_W-1:0] mixed;
    logic [WORD_W-1:0] product;
    logic [WORD_W-1:0] new_word;

    always_comb
    begin
        mixed     = in_data.w ^ (in_data.w >> 30);
        product   = mixed * INIT_MULT;
        new_word  = product + WORD_W'(step_index);
        data_next = in_data;
        data_next.w = new_word;
        if (step_index == KEEP_W1)
        begin
            data_next.w1 = new_word;
        end
        if (step_index == KEEP_W2)
        begin
            data_next.w2 = new_word;
        end
        if (step_index == KEEP_W397)
        begin
            data_next.w397 = new_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/mtfo_output_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Twists the kept words into the first two raw outputs, tempers them and
// forms the odd multipliers.
module mtfo_output_stage
    import mtfo_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire mtfo_word_t   in_data,
    output logic              done,
    output logic [WORD_W-1:0] seed_echo,
    output logic [MULT_W-1:0] x_multiplier,
    output logic [MULT_W-1:0] z_multiplier
);

    logic              done_reg;
    logic [WORD_W-1:0] seed_reg;
    logic [MULT_W-1:0] x_reg;
    logic [MULT_W-1:0] z_reg;
    logic [WORD_W-1:0] raw0;
    logic [WORD_W-1:0] raw1;
    logic [MULT_W-1:0] x_next;
    logic [MULT_W-1:0] z_next;

    always_comb
    begin
        raw0   = mtfo_temper(mtfo_twist(in_data.seed, in_data.w1, in_data.w397));
        raw1   = mtfo_temper(mtfo_twist(in_data.w1, in_data.w2, in_data.w));
        x_next = raw0[WORD_W-1:1] | MULT_W'(1);
        z_next = raw1[WORD_W-1:1] | MULT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        seed_reg <= in_data.seed;
        x_reg    <= x_next;
        z_reg    <= z_next;
    end

    assign done         = done_reg;
    assign seed_echo    = seed_reg;
    assign x_multiplier = x_reg;
    assign z_multiplier = z_reg;

endmodule

`default_nettype wire
